>>> rtl/core/md2_pkg.sv
// Shared types and constants of the MD2 digest block: the channel payloads,
// the command and status structs between sequencer and store, and the S-box.
// No dependencies.
package md2_pkg;

  // Sizes of the MD2 compression.
  localparam int unsigned BlockLen = 16;
  localparam int unsigned Rounds   = 18;
  localparam int unsigned WorkLen  = 48;

  // One input transfer.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  // One output transfer.
  typedef struct packed {
    logic [7:0] digest_byte;
    logic       digest_last;
  } out_item_t;

  // Operations that the sequencer issues to the store.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_BYTE,
    OP_PAD,
    OP_CSUM_PRE,
    OP_CSUM,
    OP_LOAD,
    OP_XOR,
    OP_ROUND,
    OP_OUT
  } op_e;

  // One issued step: operation, element index, round number and immediate byte.
  typedef struct packed {
    op_e        op;
    logic [5:0] idx;
    logic [4:0] rnd;
    logic [7:0] data;
  } cmd_t;

  // What the store reports back to the sequencer.
  typedef struct packed {
    logic       busy;
    logic       dig_valid;
    logic [7:0] dig_byte;
    logic       dig_last;
  } status_t;

  // Permutation derived from the digits of pi.
  localparam logic [7:0] SBOX [256] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

endpackage

>>> rtl/core/md2_message_digest.sv
// Top level of the MD2 digest block: channel handshakes, the step sequencer
// and the digest output register. Depends on md2_pkg and md2_store.
//
// Usage: message bytes come in on the input channel, one per transfer, with
// byte_valid set; a transfer with end_of_message set closes the message
// (with or without a byte of its own) and requests the digest. Sixteen
// digest bytes then leave on the output channel, first byte first, with
// digest_last on the sixteenth.
// Timing: a byte that does not complete a block is written into the block.
// A byte that completes a 16-byte block starts a compression: the checksum
// update, the build of the xor part, and 18 rounds of 48 chained S-box
// steps, one step a cycle through the registered read and write-back of the
// work and state memories. The end of a message adds padding, one more
// compression, the checksum compression and the digest bytes.
// Items are taken one at a time: in_stall_o stays high from an accepted
// block or end of message until its work is done.
// Reset clears hash and checksum to zero and empties the block. When the
// receiver stalls, the held digest byte stays put and the next is not read.
// After the last digest byte the block is back in its reset state.
module md2_message_digest (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  md2_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output md2_pkg::out_item_t  out_data_o
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_PAD      = 3'd1;
  localparam logic [2:0] ST_CSUM_PRE = 3'd2;
  localparam logic [2:0] ST_CSUM     = 3'd3;
  localparam logic [2:0] ST_LOAD     = 3'd4;
  localparam logic [2:0] ST_XOR      = 3'd5;
  localparam logic [2:0] ST_ROUND    = 3'd6;
  localparam logic [2:0] ST_OUT      = 3'd7;

  // Kind of block under compression.
  localparam logic [1:0] KIND_MSG    = 2'd0;
  localparam logic [1:0] KIND_PADDED = 2'd1;
  localparam logic [1:0] KIND_FINAL  = 2'd2;

  logic [2:0]         state_q, state_d;
  logic [5:0]         idx_q, idx_d;
  logic [4:0]         rnd_q, rnd_d;
  logic [3:0]         fill_q, fill_d, fill_inc;
  logic [1:0]         kind_q, kind_d;
  logic               fin_q, fin_d;
  logic               out_valid_q, out_valid_d;
  md2_pkg::out_item_t out_data_q, out_data_d;
  logic               in_ready, accept;
  md2_pkg::cmd_t      cmd;
  md2_pkg::status_t   status;

  // Input is taken only when the sequencer and the store are both idle.
  assign in_ready   = (state_q == ST_IDLE) && !status.busy;
  assign in_stall_o = !in_ready;
  assign accept     = in_valid_i && in_ready;
  assign fill_inc   = fill_q + 4'd1;

  // Sequencer: issues one step per cycle to the store; digest reads may wait.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    rnd_d   = rnd_q;
    fill_d  = fill_q;
    kind_d  = kind_q;
    fin_d   = fin_q;
    cmd     = '{op: md2_pkg::OP_NONE, default: '0};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.byte_valid) begin
            cmd.op   = md2_pkg::OP_BYTE;
            cmd.idx  = {2'b00, fill_q};
            cmd.data = in_data_i.data_byte;
          end
          if (in_data_i.byte_valid && fill_q == 4'(md2_pkg::BlockLen - 1)) begin
            // A full block is compressed at once; padding may follow.
            fill_d  = '0;
            state_d = ST_CSUM_PRE;
            kind_d  = KIND_MSG;
            fin_d   = in_data_i.end_of_message;
          end else begin
            if (in_data_i.byte_valid) begin
              fill_d = fill_inc;
            end
            if (in_data_i.end_of_message) begin
              state_d = ST_PAD;
              kind_d  = KIND_PADDED;
              idx_d   = {2'b00, in_data_i.byte_valid ? fill_inc : fill_q};
            end
          end
        end
      end
      ST_PAD: begin
        cmd.op   = md2_pkg::OP_PAD;
        cmd.idx  = idx_q;
        cmd.data = 8'(md2_pkg::BlockLen) - {4'b0000, fill_q};
        if (idx_q[3:0] == 4'(md2_pkg::BlockLen - 1)) begin
          state_d = ST_CSUM_PRE;
        end else begin
          idx_d = idx_q + 6'd1;
        end
      end
      ST_CSUM_PRE: begin
        cmd.op  = md2_pkg::OP_CSUM_PRE;
        idx_d   = '0;
        state_d = ST_CSUM;
      end
      ST_CSUM, ST_LOAD: begin
        cmd.op  = (state_q == ST_CSUM) ? md2_pkg::OP_CSUM : md2_pkg::OP_LOAD;
        cmd.idx = idx_q;
        if (idx_q[3:0] == 4'(md2_pkg::BlockLen - 1)) begin
          idx_d   = '0;
          state_d = ST_XOR;
        end else begin
          idx_d = idx_q + 6'd1;
        end
      end
      ST_XOR: begin
        cmd.op  = md2_pkg::OP_XOR;
        cmd.idx = idx_q;
        if (idx_q[3:0] == 4'(md2_pkg::BlockLen - 1)) begin
          idx_d   = '0;
          rnd_d   = '0;
          state_d = ST_ROUND;
        end else begin
          idx_d = idx_q + 6'd1;
        end
      end
      ST_ROUND: begin
        cmd.op  = md2_pkg::OP_ROUND;
        cmd.idx = idx_q;
        cmd.rnd = rnd_q;
        if (idx_q == 6'(md2_pkg::WorkLen - 1)) begin
          idx_d = '0;
          if (rnd_q == 5'(md2_pkg::Rounds - 1)) begin
            rnd_d = '0;
            // Choose what follows the compression that has just finished.
            case (kind_q)
              KIND_MSG: begin
                if (fin_q) begin
                  state_d = ST_PAD;
                  kind_d  = KIND_PADDED;
                  fin_d   = 1'b0;
                end else begin
                  state_d = ST_IDLE;
                end
              end
              KIND_PADDED: begin
                state_d = ST_LOAD;
                kind_d  = KIND_FINAL;
              end
              KIND_FINAL: state_d = ST_OUT;
              default:    state_d = ST_IDLE;
            endcase
          end else begin
            rnd_d = rnd_q + 5'd1;
          end
        end else begin
          idx_d = idx_q + 6'd1;
        end
      end
      ST_OUT: begin
        // Read the next digest byte only when the output register will be free.
        if (!status.dig_valid && (!out_valid_q || !out_stall_i)) begin
          cmd.op  = md2_pkg::OP_OUT;
          cmd.idx = idx_q;
          if (idx_q[3:0] == 4'(md2_pkg::BlockLen - 1)) begin
            idx_d   = '0;
            fill_d  = '0;
            kind_d  = KIND_MSG;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 6'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register: filled from the store, emptied by a transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (status.dig_valid) begin
      out_valid_d            = 1'b1;
      out_data_d.digest_byte = status.dig_byte;
      out_data_d.digest_last = status.dig_last;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      rnd_q       <= '0;
      fill_q      <= '0;
      kind_q      <= KIND_MSG;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rnd_q       <= rnd_d;
      fill_q      <= fill_d;
      kind_q      <= kind_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  md2_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status)
  );

  // A digest byte from the store never lands on an occupied output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.dig_valid |-> !out_valid_q)
    else $error("digest byte would overwrite the output register");

  // The last digest byte leaves the sequencer idle with an empty block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.dig_valid && status.dig_last |-> state_q == ST_IDLE && fill_q == '0)
    else $error("sequencer not back in its reset state after the digest");

  // Round and element counters stay within one compression.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND |-> rnd_q < 5'(md2_pkg::Rounds) && idx_q < 6'(md2_pkg::WorkLen))
    else $error("round counters out of range");

endmodule

>>> rtl/core/md2_store.sv
// Storage and read-modify-write datapath of the MD2 block: the work memory
// (message block and xor part) and the state memory (hash and checksum).
// Depends on md2_pkg.
module md2_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  md2_pkg::cmd_t    cmd_i,
  output md2_pkg::status_t status_o
);

  // Work memory: entries 0 to 15 hold the block, 16 to 31 the xor part.
  logic [7:0] work_mem [32];
  // State memory: entries 0 to 15 hold the hash, 16 to 31 the checksum.
  logic [7:0] state_mem [32];

  logic [31:0]   state_vld_q, state_vld_d;
  md2_pkg::cmd_t cmd_q;
  logic [4:0]    a_raddr, b_raddr, b_raddr_q;
  logic [7:0]    a_rdata_q, b_rdata_q, b_rd;
  logic [7:0]    t_q, t_d, t_new;
  logic          a_we, b_we;
  logic [4:0]    a_waddr, b_waddr;
  logic [7:0]    a_wdata, b_wdata;
  logic          low_part;

  // Read addresses follow the command being issued.
  always_comb begin
    a_raddr = '0;
    b_raddr = '0;
    case (cmd_i.op)
      md2_pkg::OP_CSUM_PRE: b_raddr = 5'(2 * md2_pkg::BlockLen - 1);
      md2_pkg::OP_CSUM: begin
        a_raddr = {1'b0, cmd_i.idx[3:0]};
        b_raddr = {1'b1, cmd_i.idx[3:0]};
      end
      md2_pkg::OP_LOAD: b_raddr = {1'b1, cmd_i.idx[3:0]};
      md2_pkg::OP_XOR: begin
        a_raddr = {1'b0, cmd_i.idx[3:0]};
        b_raddr = {1'b0, cmd_i.idx[3:0]};
      end
      md2_pkg::OP_ROUND: begin
        if (cmd_i.idx < 6'(md2_pkg::BlockLen)) begin
          b_raddr = cmd_i.idx[4:0];
        end else begin
          a_raddr = 5'(cmd_i.idx - 6'(md2_pkg::BlockLen));
        end
      end
      md2_pkg::OP_OUT: b_raddr = {1'b0, cmd_i.idx[3:0]};
      default: ;
    endcase
  end

  // Synchronous memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (a_we) begin
      work_mem[a_waddr] <= a_wdata;
    end
    a_rdata_q <= work_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      state_mem[b_waddr] <= b_wdata;
    end
    b_rdata_q <= state_mem[b_raddr];
    b_raddr_q <= b_raddr;
  end

  // A state entry that has not been written since reset or the last digest reads as zero.
  assign b_rd     = state_vld_q[b_raddr_q] ? b_rdata_q : 8'h00;
  assign low_part = cmd_q.idx < 6'(md2_pkg::BlockLen);

  // Execute stage: write command bytes, combine read data, chain byte and S-box, and write back.
  always_comb begin
    a_we        = 1'b0;
    b_we        = 1'b0;
    a_waddr     = '0;
    b_waddr     = '0;
    a_wdata     = '0;
    b_wdata     = '0;
    t_new       = '0;
    t_d         = t_q;
    state_vld_d = state_vld_q;
    unique case (cmd_q.op) inside
      md2_pkg::OP_BYTE, md2_pkg::OP_PAD: begin
        a_we    = 1'b1;
        a_waddr = {1'b0, cmd_q.idx[3:0]};
        a_wdata = cmd_q.data;
      end
      md2_pkg::OP_CSUM_PRE: t_d = b_rd;
      md2_pkg::OP_CSUM: begin
        t_new   = b_rd ^ md2_pkg::SBOX[a_rdata_q ^ t_q];
        b_we    = 1'b1;
        b_waddr = {1'b1, cmd_q.idx[3:0]};
        b_wdata = t_new;
        t_d     = t_new;
      end
      md2_pkg::OP_LOAD: begin
        a_we    = 1'b1;
        a_waddr = {1'b0, cmd_q.idx[3:0]};
        a_wdata = b_rd;
      end
      md2_pkg::OP_XOR: begin
        a_we    = 1'b1;
        a_waddr = {1'b1, cmd_q.idx[3:0]};
        a_wdata = a_rdata_q ^ b_rd;
        t_d     = '0;
      end
      md2_pkg::OP_ROUND: begin
        t_new = (low_part ? b_rd : a_rdata_q) ^ md2_pkg::SBOX[t_q];
        if (low_part) begin
          b_we    = 1'b1;
          b_waddr = cmd_q.idx[4:0];
          b_wdata = t_new;
        end else begin
          a_we    = 1'b1;
          a_waddr = 5'(cmd_q.idx - 6'(md2_pkg::BlockLen));
          a_wdata = t_new;
        end
        // The round number is added to the chain byte at the end of each round.
        if (cmd_q.idx == 6'(md2_pkg::WorkLen - 1)) begin
          t_d = t_new + {3'b000, cmd_q.rnd};
        end else begin
          t_d = t_new;
        end
      end
      md2_pkg::OP_OUT: begin
        // The last digest byte returns hash and checksum to their reset value.
        if (cmd_q.idx == 6'(md2_pkg::BlockLen - 1)) begin
          state_vld_d = '0;
        end
      end
      default: ;
    endcase
    if (b_we) begin
      state_vld_d[b_waddr] = 1'b1;
    end
  end

  // Control state of the execute stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= '{op: md2_pkg::OP_NONE, default: '0};
      state_vld_q <= '0;
    end else begin
      cmd_q       <= cmd_i;
      state_vld_q <= state_vld_d;
    end
  end

  // Chain byte.
  always_ff @(posedge clk_i) begin
    t_q <= t_d;
  end

  assign status_o.busy      = cmd_q.op != md2_pkg::OP_NONE;
  assign status_o.dig_valid = cmd_q.op == md2_pkg::OP_OUT;
  assign status_o.dig_byte  = b_rd;
  assign status_o.dig_last  = cmd_q.idx == 6'(md2_pkg::BlockLen - 1);

endmodule
